[rtl/arbt_pkg.sv]
package arbt_pkg;

  // table size default
  localparam int unsigned ARBT_REGIONS = 16;

  // field widths
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned PERM_W   = 3;
  localparam int unsigned STATUS_W = 3;

  // command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // add status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVL_NEXT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVL_PREV = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // one table entry as stored in memory
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [PERM_W-1:0] perm;
  } arbt_entry_t;

  // one command word
  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [PERM_W-1:0] perm_in;
  } arbt_req_t;

  // one result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [ADDR_W-1:0]   region_start;
    logic [LEN_W-1:0]    offset;
    logic [PERM_W-1:0]   perm_out;
  } arbt_res_t;

endpackage

[rtl/arbt_ram.sv]
module arbt_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

[rtl/arbt_ctrl.sv]
module arbt_ctrl #(
  parameter int unsigned REGIONS = arbt_pkg::ARBT_REGIONS,
  localparam int unsigned IW = (REGIONS > 1) ? $clog2(REGIONS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  arbt_pkg::arbt_req_t   req_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output arbt_pkg::arbt_res_t   res_o,
  output logic                  rd_en_o,
  output logic [IW-1:0]         rd_addr_o,
  input  arbt_pkg::arbt_entry_t rd_data_i,
  output logic                  wr_en_o,
  output logic [IW-1:0]         wr_addr_o,
  output arbt_pkg::arbt_entry_t wr_data_o
);

  import arbt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [IW-1:0] LAST_IDX = IW'(REGIONS - 1);

  logic [2:0]         state_q, state_d;
  logic [IW-1:0]      cnt_q, idx_q;
  logic               rvld_q;
  logic [REGIONS-1:0] used_q;
  logic               pred_vld_q, succ_vld_q, slot_vld_q;
  arbt_req_t          req_q;
  logic [ADDR_W-1:0]  pred_start_q, succ_start_q;
  logic [LEN_W-1:0]   pred_len_q;
  logic [PERM_W-1:0]  pred_perm_q;
  logic [IW-1:0]      slot_q;
  arbt_res_t          res_q, res_d;

  logic              in_fire, ent_used, below;
  logic              upd_pred, upd_succ, take_slot;
  logic [ADDR_W-1:0] succ_gap, pred_diff;
  logic              ovl_next, in_prev, dup;
  logic [STATUS_W-1:0] add_status;

  assign req_ready_o = (state_q == S_IDLE);
  assign in_fire     = req_valid_i && req_ready_o;

  // one table read per scan cycle
  assign rd_en_o   = (state_q == S_SCAN);
  assign rd_addr_o = cnt_q;

  // neighbor and free-slot tracking on returned read data
  assign ent_used  = used_q[idx_q];
  assign below     = (rd_data_i.start <= req_q.address);
  assign upd_pred  = rvld_q && ent_used && below &&
                     (!pred_vld_q || (rd_data_i.start > pred_start_q));
  assign upd_succ  = rvld_q && ent_used && !below &&
                     (!succ_vld_q || (rd_data_i.start < succ_start_q));
  assign take_slot = rvld_q && !ent_used && !slot_vld_q;

  // collision checks, no wrap on region ends
  assign succ_gap  = succ_start_q - req_q.address;
  assign pred_diff = req_q.address - pred_start_q;
  assign ovl_next  = succ_vld_q && (succ_gap < {{(ADDR_W-LEN_W){1'b0}}, req_q.length});
  assign in_prev   = pred_vld_q && (pred_diff < {{(ADDR_W-LEN_W){1'b0}}, pred_len_q});
  assign dup       = pred_vld_q && (pred_start_q == req_q.address);

  always_comb begin
    if (ovl_next) begin
      add_status = ST_OVL_NEXT;
    end else if (in_prev) begin
      add_status = ST_OVL_PREV;
    end else if (dup) begin
      add_status = ST_DUP;
    end else if (!slot_vld_q) begin
      add_status = ST_FULL;
    end else begin
      add_status = ST_OK;
    end
  end

  // result word
  always_comb begin
    res_d = '0;
    if (req_q.cmd == CMD_ADD) begin
      res_d.status = add_status;
    end else if (in_prev) begin
      res_d.hit          = 1'b1;
      res_d.region_start = pred_start_q;
      res_d.offset       = pred_diff[LEN_W-1:0];
      res_d.perm_out     = pred_perm_q;
    end
  end

  // insert into the first free slot; reads of the next item start later
  assign wr_en_o         = (state_q == S_CHECK) && (req_q.cmd == CMD_ADD) &&
                           (add_status == ST_OK);
  assign wr_addr_o       = slot_q;
  assign wr_data_o.start = req_q.address;
  assign wr_data_o.len   = req_q.length;
  assign wr_data_o.perm  = req_q.perm_in;

  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_SCAN;
      S_SCAN:  if (cnt_q == LAST_IDX) state_d = S_DRAIN;
      S_DRAIN: state_d = S_CHECK;
      S_CHECK: state_d = S_DONE;
      S_DONE:  if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      idx_q      <= '0;
      rvld_q     <= 1'b0;
      used_q     <= '0;
      pred_vld_q <= 1'b0;
      succ_vld_q <= 1'b0;
      slot_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= rd_en_o;
      idx_q   <= cnt_q;
      if (in_fire) begin
        cnt_q      <= '0;
        pred_vld_q <= 1'b0;
        succ_vld_q <= 1'b0;
        slot_vld_q <= 1'b0;
      end else begin
        if (rd_en_o) cnt_q <= cnt_q + 1'b1;
        if (upd_pred) pred_vld_q <= 1'b1;
        if (upd_succ) succ_vld_q <= 1'b1;
        if (take_slot) slot_vld_q <= 1'b1;
      end
      if (wr_en_o) used_q[slot_q] <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) req_q <= req_i;
    if (upd_pred) begin
      pred_start_q <= rd_data_i.start;
      pred_len_q   <= rd_data_i.len;
      pred_perm_q  <= rd_data_i.perm;
    end
    if (upd_succ) succ_start_q <= rd_data_i.start;
    if (take_slot) slot_q <= idx_q;
    if (state_q == S_CHECK) res_q <= res_d;
  end

  // an insert never lands on a live entry
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> !used_q[wr_addr_o])
    else $error("insert into used slot");

  // predecessor always lies below successor
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pred_vld_q && succ_vld_q) |-> (pred_start_q < succ_start_q))
    else $error("neighbor order broken");

  // read data only returns in the scan and drain states
  a_rd_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvld_q |-> ((state_q == S_SCAN) || (state_q == S_DRAIN)))
    else $error("stray read data");

  // a hit is only reported with a clean status
  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.hit) |-> (res_o.status == ST_OK))
    else $error("hit with error status");

  // an accepted command starts a scan
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_SCAN) && (cnt_q == '0))
    else $error("scan did not start");

endmodule

[rtl/address_region_table.sv]
// A command word passes the scan, drain, check and done states and the output
// register to m_axis_tvalid. The next is taken only back in idle; the scan reads
// every table entry through the single memory read port, one entry a cycle.
// A finished result waits in the output register while the next command runs.
// Reset (rst_ni low, asynchronous) empties the table by clearing the used bits
// at once; entry contents are left as they are and are never read unused.
module address_region_table #(
  parameter int unsigned REGIONS = arbt_pkg::ARBT_REGIONS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address[63:0], length[95:64], perm_in[98:96], zero [103:99]
  input  logic [103:0] s_axis_tdata,
  // cmd[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], hit[3], region_start[67:4], offset[99:68], perm_out[102:100],
  // zero [103]
  output logic [103:0] m_axis_tdata
);

  import arbt_pkg::*;

  localparam int unsigned IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  arbt_req_t   req;
  arbt_res_t   res, out_q;
  logic        res_valid, res_ready, out_vld_q;
  logic        rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  arbt_entry_t rd_data, wr_data;

  // unpack the command word
  assign req.cmd     = s_axis_tuser;
  assign req.address = s_axis_tdata[63:0];
  assign req.length  = s_axis_tdata[95:64];
  assign req.perm_in = s_axis_tdata[98:96];

  arbt_ctrl #(
    .REGIONS (REGIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  arbt_ram #(
    .DEPTH (REGIONS),
    .WIDTH ($bits(arbt_entry_t))
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.perm_out, out_q.offset, out_q.region_start,
                          out_q.hit, out_q.status};

endmodule
